[hw/rtl/esuc_pkg.sv]
// ----------------------------------------------------------------------------
// esuc_pkg
// Shared types and constants for the epoch seconds to UTC calendar pipeline.
// ----------------------------------------------------------------------------
package esuc_pkg;

    // Register stages from input to output register.
    localparam int NStages = 10;

    // One load enable per stage; bit 0 is the stage that takes the input.
    typedef logic [NStages-1:0] t_stage_en;

    // First stages of each group, used as enable bit indexes.
    localparam int StSplit = 0;   // stages 0..2: clamp and day split
    localparam int StCal   = 3;   // stages 3..9: time of day and date

endpackage

[hw/rtl/esuc_split.sv]
// ----------------------------------------------------------------------------
// esuc_split
// Clamps the second count and splits it into day number and second of day.
// Three stages: clamp/saturate, reciprocal multiply, remainder correction.
// ----------------------------------------------------------------------------
module esuc_split (
    input  logic                    i_clk,
    input  esuc_pkg::t_stage_en     i_en,
    input  logic signed [63:0]      i_epoch_seconds,
    output logic [21:0]             o_day_num,
    output logic [16:0]             o_sec_of_day
);

    // Last representable instant (9999-12-31 23:59:59) and the first count past it.
    localparam logic [37:0] SatSecs   = 38'(64'd2932896 * 64'd86400 + 64'd86399);
    localparam logic [37:0] SatThresh = 38'(64'd2932897 * 64'd86400);
    // 86400 = 128 * 675; floor reciprocal, estimate is low by at most one.
    localparam logic [30:0] Recip675  = 31'((64'd1 << 40) / 64'd675);
    localparam logic [10:0] DayDiv    = 11'd675;

    logic [37:0] n_secs, r_secs;
    logic [61:0] n_prod, r_prod;
    logic [30:0] r_x;
    logic [6:0]  r_lo;
    logic [21:0] w_q;
    logic [10:0] w_diff;
    logic [21:0] n_dnum, r_dnum;
    logic [9:0]  n_rem;
    logic [16:0] r_sod;
    logic        w_over;

    always_comb begin
        w_over = (|i_epoch_seconds[62:38]) || (i_epoch_seconds[37:0] >= SatThresh);
        if (i_epoch_seconds[63]) begin
            n_secs = '0;
        end else if (w_over) begin
            n_secs = SatSecs;
        end else begin
            n_secs = i_epoch_seconds[37:0];
        end
    end

    assign n_prod = 62'(r_secs[37:7]) * 62'(Recip675);

    always_comb begin
        w_q    = r_prod[61:40];
        w_diff = 11'(r_x - 31'(31'(w_q) * 31'(DayDiv)));
        if (w_diff >= DayDiv) begin
            n_dnum = w_q + 22'd1;
            n_rem  = 10'(w_diff - DayDiv);
        end else begin
            n_dnum = w_q;
            n_rem  = w_diff[9:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[esuc_pkg::StSplit]) begin
            r_secs <= n_secs;
        end
        if (i_en[esuc_pkg::StSplit + 1]) begin
            r_prod <= n_prod;
            r_x    <= r_secs[37:7];
            r_lo   <= r_secs[6:0];
        end
        if (i_en[esuc_pkg::StSplit + 2]) begin
            r_dnum <= n_dnum;
            r_sod  <= {n_rem, r_lo};
        end
    end

    assign o_day_num    = r_dnum;
    assign o_sec_of_day = r_sod;

endmodule

[hw/rtl/esuc_tod.sv]
// ----------------------------------------------------------------------------
// esuc_tod
// Second of day to hour, minute and second over four stages.
// ----------------------------------------------------------------------------
module esuc_tod (
    input  logic                    i_clk,
    input  esuc_pkg::t_stage_en     i_en,
    input  logic [16:0]             i_sec_of_day,
    output logic [4:0]              o_hour,
    output logic [5:0]              o_minute,
    output logic [5:0]              o_second
);

    // 3600 = 16 * 225 and 60 = 4 * 15; ceiling reciprocals exact over the range.
    localparam logic [12:0] Recip225 = 13'(((64'd1 << 20) + 64'd224) / 64'd225);
    localparam logic [10:0] Recip15  = 11'(((64'd1 << 14) + 64'd14) / 64'd15);

    logic [25:0] r_hprod;
    logic [16:0] r_sod;
    logic [4:0]  w_hour, r5_hour, r6_hour, r7_hour;
    logic [11:0] n_rem, r5_rem, r6_rem;
    logic [20:0] r_mprod;
    logic [5:0]  w_min, n_sec, r7_min, r7_sec;

    assign w_hour = r_hprod[24:20];
    assign n_rem  = 12'(r_sod - 17'(17'(w_hour) * 17'd3600));
    assign w_min  = r_mprod[19:14];
    assign n_sec  = 6'(r6_rem - 12'(12'(w_min) * 12'd60));

    always_ff @(posedge i_clk) begin
        if (i_en[esuc_pkg::StCal]) begin
            r_hprod <= 26'(i_sec_of_day[16:4]) * 26'(Recip225);
            r_sod   <= i_sec_of_day;
        end
        if (i_en[esuc_pkg::StCal + 1]) begin
            r5_hour <= w_hour;
            r5_rem  <= n_rem;
        end
        if (i_en[esuc_pkg::StCal + 2]) begin
            r_mprod <= 21'(r5_rem[11:2]) * 21'(Recip15);
            r6_hour <= r5_hour;
            r6_rem  <= r5_rem;
        end
        if (i_en[esuc_pkg::StCal + 3]) begin
            r7_hour <= r6_hour;
            r7_min  <= w_min;
            r7_sec  <= n_sec;
        end
    end

    assign o_hour   = r7_hour;
    assign o_minute = r7_min;
    assign o_second = r7_sec;

endmodule

[hw/rtl/esuc_date.sv]
// ----------------------------------------------------------------------------
// esuc_date
// Day number to year, month, day of month and weekday over seven stages,
// using a March-based year estimate and a Gauss month formula.
// ----------------------------------------------------------------------------
module esuc_date (
    input  logic                    i_clk,
    input  esuc_pkg::t_stage_en     i_en,
    input  logic [21:0]             i_day_num,
    output logic [4:0]              o_day_of_month,
    output logic [3:0]              o_month,
    output logic [13:0]             o_year,
    output logic [2:0]              o_weekday
);

    localparam logic [31:0] Recip146097 = 32'(((64'd1 << 49) + 64'd146096) / 64'd146097);
    localparam logic [22:0] Recip7      = 23'(((64'd1 << 25) + 64'd6) / 64'd7);
    localparam logic [11:0] Recip25     = 12'(((64'd1 << 16) + 64'd24) / 64'd25);
    localparam logic [10:0] Recip153    = 11'(((64'd1 << 18) + 64'd152) / 64'd153);
    // Day 0 moved to 1 March of 1 BC; the +2 of the estimate folded in.
    localparam logic [21:0] MarchShift  = 22'd719468;
    localparam logic [30:0] EstShift    = 31'd719470;
    localparam logic [8:0]  SplitDay    = 9'd306;

    // floor(367 * mon / 12)
    function automatic logic [8:0] month_base(input logic [3:0] mon);
        logic [8:0] v;
        case (mon)
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd152;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd305;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    logic [30:0] w_d2, n_yx, r4_yx;
    logic [21:0] n_wx, r4_wx;
    logic [44:0] r4_wprod;
    logic [21:0] r4_days, r5_days, r6_days;
    logic [62:0] r5_yprod;
    logic [2:0]  n_wday, r5_wday, r6_wday, r7_wday, r8_wday, r9_wday, r10_wday;
    logic [13:0] w_yest, r6_year, r7_year, r8_year, r9_year, r10_year;
    logic [23:0] r6_c100prod;
    logic [7:0]  w_c100;
    logic [22:0] w_base, w_ydiff;
    logic        n_leap, r7_leap;
    logic [11:0] r7_yday;
    logic [8:0]  n_yday, r8_yday, r9_yday;
    logic [13:0] n_year8;
    logic [10:0] w_y31, w_m5;
    logic [21:0] r9_mprod;
    logic [3:0]  w_mon, n_month, r10_month;
    logic [4:0]  n_mday, r10_mday;
    logic [13:0] n_year10;

    // Stage 4: year estimate numerator and weekday product
    always_comb begin
        w_d2 = 31'(i_day_num) + EstShift;
        n_yx = 31'(w_d2 << 8) + 31'(w_d2 << 7) + 31'(w_d2 << 4);
        n_wx = i_day_num + 22'd4;
    end

    // Stage 5: weekday remainder
    assign n_wday = 3'(r4_wx - 22'(22'(r4_wprod[44:25]) * 22'd7));

    // Stage 6: year estimate and century count
    assign w_yest = r5_yprod[62:49];

    // Stage 7: day of the March-based year, may come out negative
    always_comb begin
        w_c100  = r6_c100prod[23:16];
        w_base  = 23'(23'(r6_year) * 23'd365) + 23'(r6_year[13:2])
                  - 23'(w_c100) + 23'(w_c100[7:2]);
        w_ydiff = 23'(r6_days) - w_base;
        n_leap  = (r6_year[1:0] == 2'd0)
                  && ((r6_year != 14'(14'(w_c100) * 14'd100)) || (w_c100[1:0] == 2'd0));
    end

    // Stage 8: step back one year when the estimate overshot
    always_comb begin
        if (r7_yday[11]) begin
            n_yday  = 9'(r7_yday + 12'd365 + 12'(r7_leap));
            n_year8 = r7_year - 14'd1;
        end else begin
            n_yday  = r7_yday[8:0];
            n_year8 = r7_year;
        end
    end

    // Stage 9: month product
    always_comb begin
        w_y31 = 11'(r8_yday) + 11'd31;
        w_m5  = 11'(w_y31 << 2) + w_y31;
    end

    // Stage 10: month, day and January/February roll into the next year
    always_comb begin
        w_mon  = r9_mprod[21:18];
        n_mday = 5'(10'(r9_yday) + 10'd31 - 10'(month_base(w_mon)));
        if (r9_yday >= SplitDay) begin
            n_month  = w_mon - 4'd10;
            n_year10 = r9_year + 14'd1;
        end else begin
            n_month  = w_mon + 4'd2;
            n_year10 = r9_year;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[esuc_pkg::StCal]) begin
            r4_yx    <= n_yx;
            r4_wx    <= n_wx;
            r4_wprod <= 45'(n_wx) * 45'(Recip7);
            r4_days  <= i_day_num + MarchShift;
        end
        if (i_en[esuc_pkg::StCal + 1]) begin
            r5_yprod <= 63'(r4_yx) * 63'(Recip146097);
            r5_days  <= r4_days;
            r5_wday  <= n_wday;
        end
        if (i_en[esuc_pkg::StCal + 2]) begin
            r6_year     <= w_yest;
            r6_c100prod <= 24'(w_yest[13:2]) * 24'(Recip25);
            r6_days     <= r5_days;
            r6_wday     <= r5_wday;
        end
        if (i_en[esuc_pkg::StCal + 3]) begin
            r7_yday <= w_ydiff[11:0];
            r7_year <= r6_year;
            r7_leap <= n_leap;
            r7_wday <= r6_wday;
        end
        if (i_en[esuc_pkg::StCal + 4]) begin
            r8_yday <= n_yday;
            r8_year <= n_year8;
            r8_wday <= r7_wday;
        end
        if (i_en[esuc_pkg::StCal + 5]) begin
            r9_mprod <= 22'(w_m5) * 22'(Recip153);
            r9_yday  <= r8_yday;
            r9_year  <= r8_year;
            r9_wday  <= r8_wday;
        end
        if (i_en[esuc_pkg::StCal + 6]) begin
            r10_mday  <= n_mday;
            r10_month <= n_month;
            r10_year  <= n_year10;
            r10_wday  <= r9_wday;
        end
    end

    assign o_day_of_month = r10_mday;
    assign o_month        = r10_month;
    assign o_year         = r10_year;
    assign o_weekday      = r10_wday;

endmodule

[hw/rtl/epoch_seconds_to_utc_calendar.sv]
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar
// Signed Unix seconds to UTC second, minute, hour, day, month, year, weekday.
// ----------------------------------------------------------------------------
// Takes one timestamp per clock while o_stall is low and returns its calendar
// fields; the depth comes from the chain of constant-reciprocal multiplies
// (day split, year estimate, century count, month) each followed by a
// register. Negative counts read as 1970-01-01 00:00:00 and counts past the
// end of year 9999 read as 9999-12-31 23:59:59. Each stage holds its own
// valid bit and loads whenever it is empty or its successor moves, so
// bubbles close up under output stall and input is taken while a stage is
// empty, even with the output held. No reset is needed between transactions.
module epoch_seconds_to_utc_calendar (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [63:0] i_epoch_seconds,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [5:0]         o_second,
    output logic [5:0]         o_minute,
    output logic [4:0]         o_hour,
    output logic [4:0]         o_day_of_month,
    output logic [3:0]         o_month,
    output logic [13:0]        o_year,
    output logic [2:0]         o_weekday
);

    localparam int NSt = esuc_pkg::NStages;

    logic [NSt-1:0]       r_vld;
    logic [NSt:0]         w_adv;
    esuc_pkg::t_stage_en  w_en;
    logic [21:0]          w_day_num;
    logic [16:0]          w_sod;
    logic [4:0]           w_hour, r8_hour, r9_hour, r10_hour;
    logic [5:0]           w_min, r8_min, r9_min, r10_min;
    logic [5:0]           w_sec, r8_sec, r9_sec, r10_sec;

    // A stage loads when empty or when the stage after it moves.
    always_comb begin
        w_adv[NSt] = !i_stall;
        for (int k = NSt - 1; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign w_en    = w_adv[NSt-1:0];
    assign o_stall = !w_adv[0];
    assign o_valid = r_vld[NSt-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSt; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    esuc_split u_split (
        .i_clk           (i_clk),
        .i_en            (w_en),
        .i_epoch_seconds (i_epoch_seconds),
        .o_day_num       (w_day_num),
        .o_sec_of_day    (w_sod)
    );

    esuc_tod u_tod (
        .i_clk        (i_clk),
        .i_en         (w_en),
        .i_sec_of_day (w_sod),
        .o_hour       (w_hour),
        .o_minute     (w_min),
        .o_second     (w_sec)
    );

    esuc_date u_date (
        .i_clk          (i_clk),
        .i_en           (w_en),
        .i_day_num      (w_day_num),
        .o_day_of_month (o_day_of_month),
        .o_month        (o_month),
        .o_year         (o_year),
        .o_weekday      (o_weekday)
    );

    // Time of day finishes early; carry it down to the output stage.
    always_ff @(posedge i_clk) begin
        if (w_en[NSt-3]) begin
            r8_hour <= w_hour;
            r8_min  <= w_min;
            r8_sec  <= w_sec;
        end
        if (w_en[NSt-2]) begin
            r9_hour <= r8_hour;
            r9_min  <= r8_min;
            r9_sec  <= r8_sec;
        end
        if (w_en[NSt-1]) begin
            r10_hour <= r9_hour;
            r10_min  <= r9_min;
            r10_sec  <= r9_sec;
        end
    end

    assign o_hour   = r10_hour;
    assign o_minute = r10_min;
    assign o_second = r10_sec;

endmodule
